// ----- hdl/lpmm_pkg.sv -----
// Shared types, register map and reset values for the light pulse Morse matcher.
package lpmm_pkg;

  localparam int PATTERN_LEN_DEF = 8;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Symbol codes carried in the window and on symbol_code.
  localparam logic [1:0] SYM_DOT   = 2'd0;
  localparam logic [1:0] SYM_DASH  = 2'd1;
  localparam logic [1:0] SYM_SPACE = 2'd2;

  typedef enum logic [2:0] {
    REG_LIGHT_THRESHOLD = 3'd0,
    REG_DASH_TICKS      = 3'd1,
    REG_SPACE_TICKS     = 3'd2,
    REG_TIMEOUT_TICKS   = 3'd3,
    REG_PATTERN_SYMBOLS = 3'd4,
    REG_TARGET_DOTS     = 3'd5,
    REG_TARGET_DASHES   = 3'd6,
    REG_CHECK_MODE      = 3'd7
  } reg_idx_t;

  localparam logic [11:0] RST_LIGHT_THRESHOLD = 12'd100;
  localparam logic [15:0] RST_DASH_TICKS      = 16'd30;
  localparam logic [15:0] RST_SPACE_TICKS     = 16'd100;
  localparam logic [15:0] RST_TIMEOUT_TICKS   = 16'd300;
  localparam logic [15:0] RST_PATTERN_SYMBOLS = 16'd0;
  localparam logic [7:0]  RST_TARGET_DOTS     = 8'd3;
  localparam logic [7:0]  RST_TARGET_DASHES   = 8'd3;
  localparam logic [1:0]  RST_CHECK_MODE      = 2'd1;

  // Control from the tick logic to the symbol window.
  typedef struct packed {
    logic       push;
    logic [1:0] sym;
    logic       match_en;
  } win_ctl_t;

endpackage

// ----- hdl/lpmm_window.sv -----
// Window of the most recent symbols and its compare against the pattern register.
module lpmm_window #(
  parameter int PATTERN_LEN = lpmm_pkg::PATTERN_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  lpmm_pkg::win_ctl_t ctl,
  input  logic [15:0]        pattern_symbols,
  output logic               hit
);

  localparam int FW = $clog2(PATTERN_LEN + 1);

  logic [1:0]            win      [PATTERN_LEN];
  logic [1:0]            win_next [PATTERN_LEN];
  logic [FW-1:0]         fill;
  logic [FW-1:0]         fill_next;
  logic                  full;
  logic                  same;
  logic [2*PATTERN_LEN-1:0] pat_ext;

  // Pattern positions beyond the register expect a dot.
  assign pat_ext = (2*PATTERN_LEN)'(pattern_symbols);
  assign full    = (fill == FW'(PATTERN_LEN));

  always_comb begin
    for (int i = 0; i < PATTERN_LEN - 1; i++) begin
      if (full) begin
        win_next[i] = win[i+1];
      end else begin
        win_next[i] = (fill == FW'(i)) ? ctl.sym : win[i];
      end
    end
    if (full || fill == FW'(PATTERN_LEN - 1)) begin
      win_next[PATTERN_LEN-1] = ctl.sym;
    end else begin
      win_next[PATTERN_LEN-1] = win[PATTERN_LEN-1];
    end
    fill_next = full ? fill : fill + FW'(1);
    same = 1'b1;
    for (int i = 0; i < PATTERN_LEN; i++) begin
      if (win_next[i] != pat_ext[2*i +: 2]) begin
        same = 1'b0;
      end
    end
  end

  assign hit = ctl.push && ctl.match_en && (fill_next == FW'(PATTERN_LEN)) && same;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (ctl.push) begin
      fill <= hit ? '0 : fill_next;
    end
  end

  // Entries at or above the fill count never affect a hit, so they need no clearing.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      for (int i = 0; i < PATTERN_LEN; i++) begin
        win[i] <= win_next[i];
      end
    end
  end

endmodule

// ----- hdl/light_pulse_morse_matcher_core.sv -----
// Top level of the light pulse Morse matcher: tick logic, registers and handshakes.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | in_valid, in_ready, light_sample          | in
//  result    | out_valid, out_ready, symbol_valid ..     | out
//  config    | psel, penable, pwrite, paddr, pwdata ..   | in/out
//
// An item is registered on acceptance and processed from the input register, when its
// result is loaded into the output register; one item per cycle is sustained while
// the result side does not stall.
// Reset restores the register defaults and clears all tracking state.
// A stalled result holds the tick stage; input is taken while that stage can drain.
module light_pulse_morse_matcher_core #(
  parameter int PATTERN_LEN = lpmm_pkg::PATTERN_LEN_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [11:0]                 light_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        symbol_valid,
  output logic [1:0]                  symbol_code,
  output logic                        pattern_hit,
  output logic                        count_hit,
  output logic                        detected,
  output logic                        beam_present,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lpmm_pkg::ADDR_W-1:0] paddr,
  input  logic [lpmm_pkg::DATA_W-1:0] pwdata,
  output logic [lpmm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  // Configuration registers.
  logic [11:0] light_threshold;
  logic [15:0] dash_ticks;
  logic [15:0] space_ticks;
  logic [15:0] timeout_ticks;
  logic [15:0] pattern_symbols;
  logic [7:0]  target_dots;
  logic [7:0]  target_dashes;
  logic [1:0]  check_mode;

  lpmm_pkg::reg_idx_t reg_idx;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = lpmm_pkg::reg_idx_t'(paddr[4:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_threshold <= lpmm_pkg::RST_LIGHT_THRESHOLD;
      dash_ticks      <= lpmm_pkg::RST_DASH_TICKS;
      space_ticks     <= lpmm_pkg::RST_SPACE_TICKS;
      timeout_ticks   <= lpmm_pkg::RST_TIMEOUT_TICKS;
      pattern_symbols <= lpmm_pkg::RST_PATTERN_SYMBOLS;
      target_dots     <= lpmm_pkg::RST_TARGET_DOTS;
      target_dashes   <= lpmm_pkg::RST_TARGET_DASHES;
      check_mode      <= lpmm_pkg::RST_CHECK_MODE;
    end else if (cfg_write) begin
      unique case (reg_idx)
        lpmm_pkg::REG_LIGHT_THRESHOLD: light_threshold <= pwdata[11:0];
        lpmm_pkg::REG_DASH_TICKS:      dash_ticks      <= pwdata[15:0];
        lpmm_pkg::REG_SPACE_TICKS:     space_ticks     <= pwdata[15:0];
        lpmm_pkg::REG_TIMEOUT_TICKS:   timeout_ticks   <= pwdata[15:0];
        lpmm_pkg::REG_PATTERN_SYMBOLS: pattern_symbols <= pwdata[15:0];
        lpmm_pkg::REG_TARGET_DOTS:     target_dots     <= pwdata[7:0];
        lpmm_pkg::REG_TARGET_DASHES:   target_dashes   <= pwdata[7:0];
        lpmm_pkg::REG_CHECK_MODE:      check_mode      <= pwdata[1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      lpmm_pkg::REG_LIGHT_THRESHOLD: prdata = 32'(light_threshold);
      lpmm_pkg::REG_DASH_TICKS:      prdata = 32'(dash_ticks);
      lpmm_pkg::REG_SPACE_TICKS:     prdata = 32'(space_ticks);
      lpmm_pkg::REG_TIMEOUT_TICKS:   prdata = 32'(timeout_ticks);
      lpmm_pkg::REG_PATTERN_SYMBOLS: prdata = 32'(pattern_symbols);
      lpmm_pkg::REG_TARGET_DOTS:     prdata = 32'(target_dots);
      lpmm_pkg::REG_TARGET_DASHES:   prdata = 32'(target_dashes);
      lpmm_pkg::REG_CHECK_MODE:      prdata = 32'(check_mode);
    endcase
  end

  // Input register and pipeline control.
  logic        s1_valid;
  logic [11:0] s1_sample;
  logic        advance;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_sample <= light_sample;
    end
  end

  // Tracking state.
  logic [11:0] baseline;
  logic        baseline_loaded;
  logic        in_beam;
  logic [15:0] beam_ticks;
  logic [7:0]  dot_total;
  logic [7:0]  dash_total;
  logic [15:0] idle_ticks;

  logic [11:0] baseline_next;
  logic        in_beam_next;
  logic [15:0] beam_ticks_next;
  logic [7:0]  dot_total_next;
  logic [7:0]  dash_total_next;
  logic [15:0] idle_ticks_next;

  logic [11:0] diff;
  logic        beam;
  logic [15:0] idle_inc;
  logic [15:0] beam_inc;
  logic        have_dur;
  logic [15:0] dur;
  logic        sym_valid;
  logic [1:0]  sym_code;
  logic [7:0]  dot_base;
  logic [7:0]  dash_base;
  logic [7:0]  dot_add;
  logic [7:0]  dash_add;
  logic        phit;
  logic        chit;

  lpmm_pkg::win_ctl_t win_ctl;

  always_comb begin
    diff = (s1_sample >= baseline) ? s1_sample - baseline : baseline - s1_sample;
    // The first sample after reset loads the baseline and is never a beam.
    beam          = baseline_loaded && (diff > light_threshold);
    baseline_next = beam ? baseline : s1_sample;

    idle_inc = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;
    beam_inc = (beam_ticks == 16'hFFFF) ? beam_ticks : beam_ticks + 16'd1;

    have_dur        = 1'b0;
    dur             = beam_ticks;
    beam_ticks_next = beam_ticks;
    in_beam_next    = in_beam;
    if (beam) begin
      if (beam_inc >= timeout_ticks) begin
        have_dur        = 1'b1;
        dur             = timeout_ticks;
        beam_ticks_next = '0;
        in_beam_next    = 1'b0;
      end else begin
        beam_ticks_next = beam_inc;
        in_beam_next    = 1'b1;
      end
    end else if (in_beam) begin
      have_dur        = 1'b1;
      dur             = beam_ticks;
      beam_ticks_next = '0;
      in_beam_next    = 1'b0;
    end

    sym_valid = have_dur && (dur != 16'd0);
    if (dur >= space_ticks) begin
      sym_code = lpmm_pkg::SYM_SPACE;
    end else if (dur >= dash_ticks) begin
      sym_code = lpmm_pkg::SYM_DASH;
    end else begin
      sym_code = lpmm_pkg::SYM_DOT;
    end

    // A long idle gap restarts the totals before this symbol is counted.
    dot_base  = (idle_inc >= timeout_ticks) ? 8'd0 : dot_total;
    dash_base = (idle_inc >= timeout_ticks) ? 8'd0 : dash_total;
    dot_add   = (sym_code == lpmm_pkg::SYM_DOT && dot_base != 8'hFF) ?
                dot_base + 8'd1 : dot_base;
    dash_add  = (sym_code == lpmm_pkg::SYM_DASH && dash_base != 8'hFF) ?
                dash_base + 8'd1 : dash_base;

    win_ctl.push     = sym_valid && advance;
    win_ctl.sym      = sym_code;
    win_ctl.match_en = check_mode[0];
  end

  lpmm_window #(
    .PATTERN_LEN(PATTERN_LEN)
  ) u_window (
    .clk            (clk),
    .rst            (rst),
    .ctl            (win_ctl),
    .pattern_symbols(pattern_symbols),
    .hit            (phit)
  );

  always_comb begin
    chit = sym_valid && !phit && check_mode[1] &&
           (dot_add == target_dots) && (dash_add == target_dashes);

    if (sym_valid) begin
      dot_total_next  = chit ? 8'd0 : dot_add;
      dash_total_next = chit ? 8'd0 : dash_add;
      idle_ticks_next = '0;
    end else begin
      dot_total_next  = dot_total;
      dash_total_next = dash_total;
      idle_ticks_next = idle_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline        <= '0;
      baseline_loaded <= 1'b0;
      in_beam         <= 1'b0;
      beam_ticks      <= '0;
      dot_total       <= '0;
      dash_total      <= '0;
      idle_ticks      <= '0;
    end else if (advance) begin
      baseline        <= baseline_next;
      baseline_loaded <= 1'b1;
      in_beam         <= in_beam_next;
      beam_ticks      <= beam_ticks_next;
      dot_total       <= dot_total_next;
      dash_total      <= dash_total_next;
      idle_ticks      <= idle_ticks_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      symbol_valid <= sym_valid;
      symbol_code  <= sym_valid ? sym_code : lpmm_pkg::SYM_DOT;
      pattern_hit  <= phit;
      count_hit    <= chit;
      detected     <= phit || chit;
      beam_present <= beam;
    end
  end

endmodule

// ----- sim/light_pulse_morse_matcher_core_test.sv -----
// Self-checking testbench for the light pulse Morse matcher core.
`timescale 1ns / 1ps

module light_pulse_morse_matcher_core_test;

  localparam int PAT_LEN     = lpmm_pkg::PATTERN_LEN_DEF;
  localparam int HOLD_LEN    = 300;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic       sym_valid;
    logic [1:0] sym_code;
    logic       pat_hit;
    logic       cnt_hit;
    logic       det;
    logic       beam;
  } tick_result_t;

  logic                        clk          = 1'b0;
  logic                        rst          = 1'b1;
  logic                        in_valid     = 1'b0;
  logic                        out_ready    = 1'b0;
  logic [11:0]                 light_sample = '0;
  logic                        psel         = 1'b0;
  logic                        penable      = 1'b0;
  logic                        pwrite       = 1'b0;
  logic [lpmm_pkg::ADDR_W-1:0] paddr        = '0;
  logic [lpmm_pkg::DATA_W-1:0] pwdata       = '0;

  logic                        in_ready;
  logic                        out_valid;
  logic                        symbol_valid;
  logic [1:0]                  symbol_code;
  logic                        pattern_hit;
  logic                        count_hit;
  logic                        detected;
  logic                        beam_present;
  logic [lpmm_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  // Register copies kept by the predictor.
  logic [11:0] cfg_thr     = lpmm_pkg::RST_LIGHT_THRESHOLD;
  logic [15:0] cfg_dash    = lpmm_pkg::RST_DASH_TICKS;
  logic [15:0] cfg_space   = lpmm_pkg::RST_SPACE_TICKS;
  logic [15:0] cfg_tmo     = lpmm_pkg::RST_TIMEOUT_TICKS;
  logic [15:0] cfg_pattern = lpmm_pkg::RST_PATTERN_SYMBOLS;
  logic [7:0]  cfg_tdots   = lpmm_pkg::RST_TARGET_DOTS;
  logic [7:0]  cfg_tdashes = lpmm_pkg::RST_TARGET_DASHES;
  logic [1:0]  cfg_mode    = lpmm_pkg::RST_CHECK_MODE;

  // Tracking state of the predictor.
  logic [11:0] base_lvl    = '0;
  logic        base_loaded = 1'b0;
  logic        in_beam     = 1'b0;
  logic [15:0] beam_cnt    = '0;
  logic [1:0]  sym_win [PAT_LEN] = '{default: lpmm_pkg::SYM_DOT};
  int          win_fill    = 0;
  logic [7:0]  dots        = '0;
  logic [7:0]  dashes      = '0;
  logic [15:0] idle_cnt    = '0;

  tick_result_t expected_ticks [$];

  int mismatches    = 0;
  int items_sent    = 0;
  int send_idle_pct = 27;
  int recv_idle_pct = 82;
  int rest_level    = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;

  light_pulse_morse_matcher_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .light_sample (light_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol_valid (symbol_valid),
    .symbol_code  (symbol_code),
    .pattern_hit  (pattern_hit),
    .count_hit    (count_hit),
    .detected     (detected),
    .beam_present (beam_present),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #4 clk = ~clk;

  function automatic void predict_tick(input logic [11:0] sample);
    logic [11:0]  diff;
    logic         beam;
    logic         have_dur;
    logic [15:0]  dur;
    logic [1:0]   code;
    logic         win_match;
    tick_result_t res;
    res      = '0;
    have_dur = 1'b0;
    dur      = '0;
    code     = lpmm_pkg::SYM_DOT;
    // The first sample after reset becomes the baseline, so it is never a beam.
    if (!base_loaded) begin
      base_lvl    = sample;
      base_loaded = 1'b1;
    end
    diff = (sample >= base_lvl) ? sample - base_lvl : base_lvl - sample;
    beam = diff > cfg_thr;
    if (!beam) base_lvl = sample;
    if (idle_cnt != 16'hFFFF) idle_cnt++;
    if (beam) begin
      if (beam_cnt != 16'hFFFF) beam_cnt++;
      in_beam = 1'b1;
      if (beam_cnt >= cfg_tmo) begin
        have_dur = 1'b1;
        dur      = cfg_tmo;
        beam_cnt = '0;
        in_beam  = 1'b0;
      end
    end else if (in_beam) begin
      have_dur = 1'b1;
      dur      = beam_cnt;
      beam_cnt = '0;
      in_beam  = 1'b0;
    end
    if (have_dur && dur != 16'd0) begin
      if (dur >= cfg_space) code = lpmm_pkg::SYM_SPACE;
      else if (dur >= cfg_dash) code = lpmm_pkg::SYM_DASH;
      else code = lpmm_pkg::SYM_DOT;
      if (win_fill == PAT_LEN) begin
        for (int i = 0; i < PAT_LEN - 1; i++) sym_win[i] = sym_win[i + 1];
        sym_win[PAT_LEN - 1] = code;
      end else begin
        sym_win[win_fill] = code;
        win_fill++;
      end
      // A long quiet stretch clears the totals before this symbol is counted.
      if (idle_cnt >= cfg_tmo) begin
        dots   = '0;
        dashes = '0;
      end
      if (code == lpmm_pkg::SYM_DOT && dots != 8'hFF) dots++;
      if (code == lpmm_pkg::SYM_DASH && dashes != 8'hFF) dashes++;
      idle_cnt  = '0;
      win_match = (win_fill == PAT_LEN);
      for (int i = 0; i < PAT_LEN; i++) begin
        if (sym_win[i] != cfg_pattern[2*i +: 2]) win_match = 1'b0;
      end
      if (cfg_mode[0] && win_match) begin
        win_fill    = 0;
        sym_win     = '{default: lpmm_pkg::SYM_DOT};
        res.pat_hit = 1'b1;
      end else if (cfg_mode[1] && dots == cfg_tdots && dashes == cfg_tdashes) begin
        dots        = '0;
        dashes      = '0;
        res.cnt_hit = 1'b1;
      end
      res.sym_valid = 1'b1;
      res.sym_code  = code;
    end
    res.det  = res.pat_hit | res.cnt_hit;
    res.beam = beam;
    expected_ticks.push_back(res);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_tick(light_sample);
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        mismatches++;
      end else begin
        want = expected_ticks.pop_front();
        check_field("symbol_valid", 16'(want.sym_valid), 16'(symbol_valid));
        check_field("symbol_code", 16'(want.sym_code), 16'(symbol_code));
        check_field("pattern_hit", 16'(want.pat_hit), 16'(pattern_hit));
        check_field("count_hit", 16'(want.cnt_hit), 16'(count_hit));
        check_field("detected", 16'(want.det), 16'(detected));
        check_field("beam_present", 16'(want.beam), 16'(beam_present));
      end
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leaves valid high after acceptance; the next caller either reuses or drops it.
  task automatic send_sample(input logic [11:0] value);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    light_sample <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input lpmm_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      lpmm_pkg::REG_LIGHT_THRESHOLD: cfg_thr     = value[11:0];
      lpmm_pkg::REG_DASH_TICKS:      cfg_dash    = value[15:0];
      lpmm_pkg::REG_SPACE_TICKS:     cfg_space   = value[15:0];
      lpmm_pkg::REG_TIMEOUT_TICKS:   cfg_tmo     = value[15:0];
      lpmm_pkg::REG_PATTERN_SYMBOLS: cfg_pattern = value[15:0];
      lpmm_pkg::REG_TARGET_DOTS:     cfg_tdots   = value[7:0];
      lpmm_pkg::REG_TARGET_DASHES:   cfg_tdashes = value[7:0];
      lpmm_pkg::REG_CHECK_MODE:      cfg_mode    = value[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_registers(input int thr, input int dash, input int space,
                                input int tmo, input int pat, input int tdots,
                                input int tdashes, input int mode);
    wait_drained();
    write_reg(lpmm_pkg::REG_LIGHT_THRESHOLD, thr);
    write_reg(lpmm_pkg::REG_DASH_TICKS, dash);
    write_reg(lpmm_pkg::REG_SPACE_TICKS, space);
    write_reg(lpmm_pkg::REG_TIMEOUT_TICKS, tmo);
    write_reg(lpmm_pkg::REG_PATTERN_SYMBOLS, pat);
    write_reg(lpmm_pkg::REG_TARGET_DOTS, tdots);
    write_reg(lpmm_pkg::REG_TARGET_DASHES, tdashes);
    write_reg(lpmm_pkg::REG_CHECK_MODE, mode);
    // Pulses are built around the level the baseline sits at right now.
    rest_level = int'(base_lvl);
  endtask

  // Stays within a quarter threshold of the rest level, so it never reads as beam.
  function automatic logic [11:0] quiet_sample();
    int jit;
    int v;
    jit = int'(cfg_thr) / 4;
    v   = rest_level - jit + int'($urandom_range(2 * jit, 0));
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  function automatic logic [11:0] beam_sample();
    int margin;
    bit up_ok;
    bit down_ok;
    margin  = int'(cfg_thr) + int'(cfg_thr) / 4 + 1 + int'($urandom_range(24, 0));
    up_ok   = (rest_level + margin <= 4095);
    down_ok = (rest_level - margin >= 0);
    if (up_ok && (!down_ok || $urandom_range(1, 0) == 1)) return 12'(rest_level + margin);
    if (down_ok) return 12'(rest_level - margin);
    return 12'd4095;
  endfunction

  task automatic send_beam(input int ticks, input int gap);
    repeat (ticks) send_sample(beam_sample());
    repeat (gap) send_sample(quiet_sample());
  endtask

  task automatic send_pulse(input logic [1:0] code, input int gap);
    int lo;
    int hi;
    case (code)
      lpmm_pkg::SYM_DOT: begin
        lo = 1;
        hi = int'(cfg_dash) - 1;
      end
      lpmm_pkg::SYM_DASH: begin
        lo = int'(cfg_dash);
        hi = int'(cfg_space) - 1;
      end
      default: begin
        lo = int'(cfg_space);
        hi = int'(cfg_space) + 1;
      end
    endcase
    if (lo < 1) lo = 1;
    if (lo > 400) lo = 400;
    if (hi > 400) hi = 400;
    if (hi < lo) hi = lo;
    send_beam($urandom_range(hi, lo), gap);
  endtask

  // Reset values: first sample, threshold edge and the all-dot pattern.
  task automatic test_power_up_defaults();
    int seq [20] = '{4095, 4095, 0, 4095, 0, 0, 4095, 0, 4095, 0,
                     4095, 0, 4095, 0, 4095, 0, 4095, 3995, 3894, 3995};
    foreach (seq[i]) send_sample(12'(seq[i]));
  endtask

  task automatic test_register_extremes();
    load_registers(4095, 65535, 65535, 65535, 16'hFFFF, 255, 255, 3);
    repeat (40) send_sample(12'($urandom_range(4095, 0)));
    load_registers(0, 0, 0, 1, 0, 0, 0, 0);
    repeat (40) send_sample(12'($urandom_range(4095, 0)));
    load_registers(0, 0, 65535, 65535, 16'h5555, 0, 255, 2);
    repeat (40) send_sample(12'($urandom_range(4095, 0)));
    load_registers(2047, 1, 2, 2, 16'hAAAA, 1, 1, 1);
    repeat (40) send_sample(12'($urandom_range(4095, 0)));
  endtask

  task automatic test_beam_timeout_and_idle();
    load_registers(100, 2, 4, 5, 0, 2, 0, 2);
    // A long beam is cut at the timeout and carries on as new symbols.
    send_beam(12, 1);
    send_pulse(lpmm_pkg::SYM_DOT, 8);
    send_pulse(lpmm_pkg::SYM_DOT, 1);
    send_pulse(lpmm_pkg::SYM_DOT, 1);
    load_registers(100, 1, 2, 1, 0, 0, 4, 2);
    send_beam(4, 2);
  endtask

  // All-dot pattern and count targets that both match: the pattern wins.
  task automatic test_pattern_priority();
    load_registers(100, 3, 6, 10, 16'h0000, 8, 0, 3);
    send_beam(0, 12);
    repeat (8) send_pulse(lpmm_pkg::SYM_DOT, 1);
    send_pulse(lpmm_pkg::SYM_SPACE, 1);
  endtask

  task automatic test_total_saturation();
    load_registers(200, 3, 6, 20, 16'hFFFF, 255, 1, 2);
    repeat (262) send_pulse(lpmm_pkg::SYM_DOT, 1);
    send_pulse(lpmm_pkg::SYM_DASH, 2);
  endtask

  task automatic test_output_backpressure();
    hold_req <= hold_req + 1;
    repeat (25) send_pulse(2'($urandom_range(2, 0)), 1);
    wait_drained();
    repeat (10) send_pulse(2'($urandom_range(2, 0)), 1);
  endtask

  task automatic test_random_traffic(input int configs, input int items_each);
    int          dash;
    int          space;
    int          tmo;
    int          pat;
    int          start;
    int          pick;
    logic [1:0]  code;
    repeat (configs) begin
      dash  = $urandom_range(6, 2);
      space = dash + $urandom_range(5, 1);
      tmo   = space - 2 + $urandom_range(8, 0);
      pat   = 0;
      if ($urandom_range(3, 0) != 0) begin
        for (int i = 0; i < 8; i++) pat |= $urandom_range(2, 0) << (2 * i);
      end else begin
        pat = $urandom_range(16'hFFFF, 0);
      end
      load_registers($urandom_range(300, 0), dash, space, tmo, pat,
                     $urandom_range(4, 0), $urandom_range(4, 0), $urandom_range(3, 0));
      start = items_sent;
      while (items_sent - start < items_each) begin
        pick = $urandom_range(99, 0);
        if (pick < 10) begin
          send_beam($urandom_range(tmo + 3, 1), $urandom_range(tmo + 2, 1));
        end else if (pick < 35) begin
          for (int i = 0; i < 8; i++) begin
            code = cfg_pattern[2*i +: 2];
            if (code == 2'd3) code = 2'($urandom_range(2, 0));
            send_pulse(code, $urandom_range(3, 1));
          end
        end else begin
          code = 2'($urandom_range(2, 0));
          if ($urandom_range(19, 0) == 0) send_pulse(code, tmo + $urandom_range(2, 0));
          else send_pulse(code, $urandom_range(3, 1));
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 27;
    recv_idle_pct = 82;
    test_power_up_defaults();
    test_register_extremes();
    test_beam_timeout_and_idle();
    test_pattern_priority();
    test_random_traffic(3, 60);

    send_idle_pct = 82;
    recv_idle_pct = 27;
    test_total_saturation();
    test_random_traffic(3, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_backpressure();
    test_random_traffic(3, 60);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lpmm_pkg.sv
hdl/lpmm_window.sv
hdl/light_pulse_morse_matcher_core.sv
sim/light_pulse_morse_matcher_core_test.sv
